[design/signed_integer_to_base_digits_unit_macros.svh]
// Assertion helpers for the integer-to-text unit.
// All checks are clocked on clock and switched off while reset is high.
`ifndef SIGNED_INTEGER_TO_BASE_DIGITS_UNIT_MACROS_SVH
`define SIGNED_INTEGER_TO_BASE_DIGITS_UNIT_MACROS_SVH

// Same-cycle implication.
`define SITBD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SITBD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/sitbd_pkg.sv]
`timescale 1ns / 1ps

package sitbd_pkg;

   localparam int VALUE_WIDTH_DEF = 64;
   localparam int RADIX_W         = 5;
   localparam int CHAR_W          = 7;
   localparam int DIGIT_W         = 4;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] BASE_MIN    = 5'd2;
   localparam logic [RADIX_W-1:0] BASE_MAX    = 5'd16;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
   localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOW_F = 7'h66;

   // csr register indexes
   localparam logic REG_RADIX = 1'b0;

   // control info for one number, front to back
   typedef struct packed {
      logic               neg;
      logic [RADIX_W-1:0] base;
   } job_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MINUS,
      ST_FETCH,
      ST_EMIT
   } back_state_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      case (d)
         4'd0:    c = 7'h30;
         4'd1:    c = 7'h31;
         4'd2:    c = 7'h32;
         4'd3:    c = 7'h33;
         4'd4:    c = 7'h34;
         4'd5:    c = 7'h35;
         4'd6:    c = 7'h36;
         4'd7:    c = 7'h37;
         4'd8:    c = 7'h38;
         4'd9:    c = 7'h39;
         4'd10:   c = 7'h61;
         4'd11:   c = 7'h62;
         4'd12:   c = 7'h63;
         4'd13:   c = 7'h64;
         4'd14:   c = 7'h65;
         4'd15:   c = 7'h66;
         default: c = CHAR_ZERO;
      endcase
      return c;
   endfunction

endpackage

[design/signed_integer_to_base_digits_unit.sv]
`timescale 1ns / 1ps
// Signed integer to ASCII text in base 2..16.
// req_*: one transfer carries one two's complement value (low VALUE_WIDTH bits used).
// rsp_*: one transfer per character, most significant digit first, '-' ahead of
//   a negative number, digits 0-9 then a-f; rsp_tlast marks the final digit.
// csr_*: APB-style port, radix register at byte address 0 (reset 10); values
//   below 2 act as base 2, above 16 as base 16. Write only while idle.
// Flow: the front classifies a value in the accepting cycle and queues it
//   (two entries). The back divides by the base 8 bits per cycle; each digit
//   takes a full pass over the padded value, then each character is fetched
//   through the digit memory read (ST_FETCH, then ST_EMIT). The back takes a
//   new value only when idle, once the last character of the previous value
//   has been loaded into its output register.
// Reset: radix back to 10, queue empty, back end idle, no result pending.
// Stall: a held rsp transfer stops the back end at its next character; the
//   queue keeps taking values until both entries are full, then req_tready drops.
`include "signed_integer_to_base_digits_unit_macros.svh"

module signed_integer_to_base_digits_unit
   import sitbd_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // [63:0] value
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [6:0] character, [7] zero
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [RADIX_W-1:0]     radix_ff, radix_in;
   logic                   csr_wr;
   logic                   radix_wr;
   logic [RADIX_W-1:0]     wr_radix;
   logic                   job_valid, job_ready;
   job_ctl_type            job_ctl;
   logic [VALUE_WIDTH-1:0] job_mag;
   logic [CHAR_W-1:0]      rsp_char;
   logic                   rsp_minus;
   logic                   rsp_char_ok;

   // ---- configuration register ----
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign radix_wr   = csr_wr && (csr_paddr[2] == REG_RADIX);
   assign wr_radix   = csr_pwdata[RADIX_W-1:0];

   always_comb begin
      radix_in = radix_ff;
      if (radix_wr) begin
         radix_in = wr_radix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_RADIX) ? 32'(radix_ff) : 32'd0;

   // ---- front: sign, magnitude, base; two-entry queue ----
   sitbd_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .radix     (radix_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_value  (req_tdata),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_ctl   (job_ctl),
      .job_mag   (job_mag)
   );

   // ---- back: digit divider, digit memory, character output ----
   sitbd_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_ctl   (job_ctl),
      .job_mag   (job_mag),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_char),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_char};

   // ---- checks ----
   assign rsp_minus   = (rsp_char == CHAR_MINUS);
   assign rsp_char_ok = rsp_minus
                        || ((rsp_char >= CHAR_ZERO) && (rsp_char <= CHAR_NINE))
                        || ((rsp_char >= CHAR_LOW_A) && (rsp_char <= CHAR_LOW_F));

   `SITBD_ASSERT_IMP(a_char_legal, rsp_tvalid, rsp_char_ok, "illegal character on rsp")
   `SITBD_ASSERT_IMP(a_minus_not_last, rsp_tvalid && rsp_minus, !rsp_tlast, "minus flagged last")
   `SITBD_ASSERT_NXT(a_job_held, job_valid && !job_ready, job_valid, "queued job dropped")
   `SITBD_ASSERT_NXT(a_radix_write, radix_wr, radix_ff == $past(wr_radix), "radix write lost")

endmodule

[design/sitbd_ram.sv]
`timescale 1ns / 1ps

module sitbd_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/sitbd_front.sv]
`timescale 1ns / 1ps

module sitbd_front
   import sitbd_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [RADIX_W-1:0]     radix,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [63:0]            in_value,
   output logic                   job_valid,
   input  logic                   job_ready,
   output job_ctl_type            job_ctl,
   output logic [VALUE_WIDTH-1:0] job_mag
);

   localparam logic [VALUE_WIDTH-1:0] TOP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   logic [VALUE_WIDTH-1:0] v;
   logic [VALUE_WIDTH-1:0] mag;
   job_ctl_type            ctl;

   job_ctl_type            ctl_q_ff [2];
   logic [VALUE_WIDTH-1:0] mag_q_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic                   push, pop;

   // classify: sign, saturated magnitude, clamped base
   always_comb begin
      v        = in_value[VALUE_WIDTH-1:0];
      ctl.neg  = v[VALUE_WIDTH-1];
      if (v == TOP) begin
         mag = ~TOP;
      end else if (v[VALUE_WIDTH-1]) begin
         mag = ~v + 1'b1;
      end else begin
         mag = v;
      end
      if (radix < BASE_MIN) begin
         ctl.base = BASE_MIN;
      end else if (radix > BASE_MAX) begin
         ctl.base = BASE_MAX;
      end else begin
         ctl.base = radix;
      end
   end

   // two-entry queue toward the converter
   assign in_ready  = (count_ff != 2'd2);
   assign job_valid = (count_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = job_valid && job_ready;
   assign job_ctl   = ctl_q_ff[rd_ptr_ff];
   assign job_mag   = mag_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_q_ff[wr_ptr_ff] <= ctl;
         mag_q_ff[wr_ptr_ff] <= mag;
      end
   end

endmodule

[design/sitbd_back.sv]
`timescale 1ns / 1ps

module sitbd_back
   import sitbd_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  job_ctl_type            job_ctl,
   input  logic [VALUE_WIDTH-1:0] job_mag,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [CHAR_W-1:0]      out_char,
   output logic                   out_last
);

   localparam int PAD_W  = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int STEPS  = PAD_W / 8;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int ADDR_W = $clog2(VALUE_WIDTH);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

   back_state_type       state_ff, state_in;
   logic [PAD_W-1:0]     q_ff, q_in;
   logic [RADIX_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [ADDR_W-1:0]    nd_ff, nd_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   logic                 neg_ff, neg_in;
   logic [RADIX_W-1:0]   base_ff, base_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]    out_char_ff, out_char_in;
   logic                 out_last_ff, out_last_in;

   logic [RADIX_W-1:0]   r;
   logic [7:0]           top_byte;
   logic [7:0]           qb;
   logic [PAD_W-1:0]     q_shift;
   logic                 digit_done;
   logic                 out_free;
   logic                 ram_wr_en;
   logic [DIGIT_W-1:0]   ram_rd_data;

   // eight restoring steps of long division by a small base
   always_comb begin
      r        = rem_ff;
      top_byte = q_ff[PAD_W-1 -: 8];
      qb       = 8'd0;
      for (int i = 7; i >= 0; i--) begin
         r = {r[RADIX_W-2:0], top_byte[i]};
         if (r >= base_ff) begin
            r     = r - base_ff;
            qb[i] = 1'b1;
         end
      end
      q_shift = (q_ff << 8) | PAD_W'(qb);
   end

   assign digit_done = (state_ff == ST_DIV) && (step_ff == STEP_LAST);
   assign out_free   = !out_valid_ff || out_ready;
   assign ram_wr_en  = digit_done;
   assign job_ready  = (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (digit_done && (q_shift == '0)) begin
               state_in = neg_ff ? ST_MINUS : ST_FETCH;
            end
         end
         ST_MINUS: begin
            if (out_free) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = (idx_ff == '0) ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and output register
   always_comb begin
      q_in         = q_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      nd_in        = nd_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      base_in      = base_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               q_in    = PAD_W'(job_mag);
               rem_in  = '0;
               step_in = '0;
               nd_in   = '0;
               neg_in  = job_ctl.neg;
               base_in = job_ctl.base;
            end
         end
         ST_DIV: begin
            q_in    = q_shift;
            rem_in  = r;
            step_in = step_ff + 1'b1;
            if (digit_done) begin
               step_in = '0;
               rem_in  = '0;
               if (q_shift == '0) begin
                  idx_in = nd_ff;
               end else begin
                  nd_in = nd_ff + 1'b1;
               end
            end
         end
         ST_MINUS: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_MINUS;
               out_last_in  = 1'b0;
            end
         end
         ST_FETCH: begin
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = digit_char(ram_rd_data);
               out_last_in  = (idx_ff == '0);
               if (idx_ff != '0) begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      nd_ff       <= nd_in;
      idx_ff      <= idx_in;
      neg_ff      <= neg_in;
      base_ff     <= base_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // digits land least significant first, read back in reverse
   sitbd_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (VALUE_WIDTH)
   ) u_digits (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (nd_ff),
      .wr_data (r[DIGIT_W-1:0]),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign out_valid = out_valid_ff;
   assign out_char  = out_char_ff;
   assign out_last  = out_last_ff;

endmodule
